/* hw/rtl/bmp8hc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8hc_pkg
// Shared types and constants of the 8 bpp bitmap header check and row unpad
// block: phase codes, status codes, command beat and header layout.
// ----------------------------------------------------------------------------
package bmp8hc_pkg;

  // header layout
  localparam int HDR_BYTES    = 34;
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
  localparam int HDR_TOTAL    = 54;
  localparam int HDR_END      = 53;
  localparam int FILE_HDR     = 14;
  localparam int DIB_MIN      = 40;
  localparam logic [7:0]  MAGIC_B   = 8'h42;
  localparam logic [7:0]  MAGIC_M   = 8'h4D;
  localparam logic [15:0] PLANES_ONE = 16'd1;
  localparam logic [15:0] BPP_EIGHT  = 16'd8;

  // beats in the header phase on which the size check is prepared
  localparam int STEP_PREP  = 34;
  localparam int STEP_LO    = 35;
  localparam int STEP_HI    = 36;
  localparam int STEP_SUM   = 37;
  localparam int STEP_TOTAL = 38;

  // command queue
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FORMAT     = 2'd1,
    ST_NOT8       = 2'd2,
    ST_COMPRESSED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_PIXEL  = 1'b1
  } result_kind_t;

  typedef enum logic {
    CMD_STATUS = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic [7:0]  data;
    logic [30:0] width;
    logic [31:0] height;
    logic [31:0] offset;
    logic [31:0] row_len;
    logic [31:0] rows;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/bmp8_header_check_and_row_unpad.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8_header_check_and_row_unpad
// Parses an 8 bpp uncompressed bitmap streamed one byte per beat: checks
// the header, reports one status beat, then emits unpadded pixel bytes.
// ----------------------------------------------------------------------------
// a byte's command is written to the queue on the edge that takes it; the
//   result register is loaded when the back pops that command
// throughput: one byte per cycle while the 4-entry command queue has room;
//   the back drains one command per cycle while no out beat waits unpopped
// reset: synchronous active low; clears position, phase, queue, row counters
//   and the file length; captured header bytes are not reset
module bmp8_header_check_and_row_unpad
  import bmp8hc_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [31:0]   cfg_file_length,
  input  wire logic          in_push,
  input  wire logic [7:0]    in_data_byte,
  output logic               in_full,
  input  wire logic          out_pop,
  output logic               out_empty,
  output logic               out_kind,
  output logic [1:0]         out_status,
  output logic [7:0]         out_pixel,
  output logic [30:0]        out_image_width,
  output logic signed [31:0] out_image_height,
  output logic [31:0]        out_pixel_data_offset,
  output logic               out_last_pixel
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_empty;
  logic accept;

  assign accept = in_push && !in_full;

  bmp8hc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_file_length (cfg_file_length),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .cmd             (push_cmd),
    .cmd_push        (push)
  );

  bmp8hc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (in_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  bmp8hc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_avail             (!q_empty),
    .cmd                   (pop_cmd),
    .cmd_pop               (pop),
    .out_pop               (out_pop),
    .out_empty             (out_empty),
    .out_kind              (out_kind),
    .out_status            (out_status),
    .out_pixel             (out_pixel),
    .out_image_width       (out_image_width),
    .out_image_height      (out_image_height),
    .out_pixel_data_offset (out_pixel_data_offset),
    .out_last_pixel        (out_last_pixel)
  );

endmodule
`default_nettype wire

/* hw/rtl/bmp8hc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8hc_front
// Byte position, header capture and header check. Classifies each accepted
// byte and, where one is due, hands a status or pixel-data command to the queue.
// ----------------------------------------------------------------------------
module bmp8hc_front
  import bmp8hc_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_file_length,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  output cmd_t             cmd,
  output logic             cmd_push
);

  localparam logic [LENGTH_BITS-1:0] POS_MAX   = '1;
  localparam logic [LENGTH_BITS-1:0] POS_END   = LENGTH_BITS'(HDR_END);
  localparam logic [LENGTH_BITS-1:0] POS_HBYTES = LENGTH_BITS'(HDR_BYTES);
  localparam logic [LENGTH_BITS-1:0] LEN_MIN   = LENGTH_BITS'(HDR_TOTAL);

  logic [LENGTH_BITS-1:0] flen_r;
  logic [LENGTH_BITS-1:0] pos_r;
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             hdr_r [HDR_BYTES];

  logic [31:0] row_r;
  logic [31:0] habs_r;
  logic [32:0] dibsum_r;
  logic        pre_fmt_r;
  logic        bpp_bad_r;
  logic        cmp_bad_r;
  logic        off_lt_r;
  logic [47:0] prod_lo_r;
  logic [47:0] prod_hi_r;
  logic [63:0] prod_r;
  logic [63:0] total_r;

  logic [31:0] f_off, f_dib, f_w, f_h, f_cmp;
  logic [15:0] f_planes, f_bpp;
  logic        hdr_phase_beat;
  logic        short_hit;
  logic        fmt_bad;
  status_t     hdr_status;

  assign f_off    = {hdr_r[13], hdr_r[12], hdr_r[11], hdr_r[10]};
  assign f_dib    = {hdr_r[17], hdr_r[16], hdr_r[15], hdr_r[14]};
  assign f_w      = {hdr_r[21], hdr_r[20], hdr_r[19], hdr_r[18]};
  assign f_h      = {hdr_r[25], hdr_r[24], hdr_r[23], hdr_r[22]};
  assign f_planes = {hdr_r[27], hdr_r[26]};
  assign f_bpp    = {hdr_r[29], hdr_r[28]};
  assign f_cmp    = {hdr_r[33], hdr_r[32], hdr_r[31], hdr_r[30]};

  assign hdr_phase_beat = accept && (phase_r == PH_HEADER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r  <= '0;
      pos_r   <= '0;
      phase_r <= PH_HEADER;
    end else begin
      if (cfg_wr_en) begin
        flen_r <= cfg_file_length[LENGTH_BITS-1:0];
      end
      if (accept && pos_r != POS_MAX) begin
        pos_r <= pos_r + 1'b1;
      end
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_phase_beat && pos_r < POS_HBYTES) begin
      hdr_r[pos_r[HDR_IDX_W-1:0]] <= data_byte;
    end
  end

  // size check prepared over the beats that follow the captured header
  always_ff @(posedge clk) begin
    if (hdr_phase_beat) begin
      if (pos_r == LENGTH_BITS'(STEP_PREP)) begin
        row_r     <= ({1'b0, f_w[30:0]} + 32'd3) & ~32'd3;
        habs_r    <= f_h[31] ? (~f_h + 32'd1) : f_h;
        dibsum_r  <= 33'(f_dib) + 33'(FILE_HDR);
        pre_fmt_r <= (hdr_r[0] != MAGIC_B) || (hdr_r[1] != MAGIC_M)
                     || (f_dib < 32'(DIB_MIN)) || (f_w == '0) || f_w[31]
                     || (f_h == '0) || (f_planes != PLANES_ONE);
        bpp_bad_r <= f_bpp != BPP_EIGHT;
        cmp_bad_r <= f_cmp != '0;
      end
      if (pos_r == LENGTH_BITS'(STEP_LO)) begin
        off_lt_r  <= 33'(f_off) < dibsum_r;
        prod_lo_r <= 48'(row_r) * 48'(habs_r[15:0]);
      end
      if (pos_r == LENGTH_BITS'(STEP_HI)) begin
        prod_hi_r <= 48'(row_r) * 48'(habs_r[31:16]);
      end
      if (pos_r == LENGTH_BITS'(STEP_SUM)) begin
        prod_r <= 64'(prod_lo_r) + {prod_hi_r, 16'd0};
      end
      if (pos_r == LENGTH_BITS'(STEP_TOTAL)) begin
        total_r <= prod_r + 64'(f_off);
      end
    end
  end

  assign short_hit = ({1'b0, pos_r} + 1'b1) >= {1'b0, flen_r};
  assign fmt_bad   = pre_fmt_r || off_lt_r || (33'(flen_r) < dibsum_r)
                     || (f_off > 32'(flen_r));

  always_comb begin
    if (fmt_bad) begin
      hdr_status = ST_FORMAT;
    end else if (bpp_bad_r) begin
      hdr_status = ST_NOT8;
    end else if (cmp_bad_r) begin
      hdr_status = ST_COMPRESSED;
    end else if (total_r > 64'(flen_r)) begin
      hdr_status = ST_FORMAT;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.kind       = CMD_DATA;
    cmd.status     = ST_OK;
    cmd.data       = data_byte;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          if (flen_r < LEN_MIN) begin
            if (short_hit) begin
              cmd_push   = 1'b1;
              cmd.kind   = CMD_STATUS;
              cmd.status = ST_FORMAT;
              phase_nxt  = PH_DONE;
            end
          end else if (pos_r == POS_END) begin
            cmd_push   = 1'b1;
            cmd.kind   = CMD_STATUS;
            cmd.status = hdr_status;
            if (hdr_status == ST_OK) begin
              cmd.width   = f_w[30:0];
              cmd.height  = f_h;
              cmd.offset  = f_off;
              cmd.row_len = row_r;
              cmd.rows    = habs_r;
              phase_nxt   = PH_SKIP;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SKIP: begin
          if (32'(pos_r) >= f_off) begin
            cmd_push  = 1'b1;
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          cmd_push = 1'b1;
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bmp8hc_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8hc_cmd_fifo
// Short register queue of command beats between the front and back parts.
// ----------------------------------------------------------------------------
module bmp8hc_cmd_fifo
  import bmp8hc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = count_r == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bmp8hc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8hc_back
// Row unpadder and result register. Turns status and data commands into
// result beats, dropping the padding bytes at the end of each row.
// ----------------------------------------------------------------------------
module bmp8hc_back
  import bmp8hc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_avail,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  wire logic         out_pop,
  output logic              out_empty,
  output logic              out_kind,
  output logic [1:0]        out_status,
  output logic [7:0]        out_pixel,
  output logic [30:0]       out_image_width,
  output logic signed [31:0] out_image_height,
  output logic [31:0]       out_pixel_data_offset,
  output logic              out_last_pixel
);

  logic        valid_r;
  logic        active_r;
  logic [30:0] w_r;
  logic [31:0] prl_r;
  logic [31:0] rows_r;
  logic [31:0] col_r;

  result_kind_t kind_r;
  status_t      status_r;
  logic [7:0]   pixel_r;
  logic [30:0]  width_r;
  logic [31:0]  height_r;
  logic [31:0]  offset_r;
  logic         last_r;

  logic        slot_free;
  logic        is_data;
  logic        emit_pix;
  logic        emit;
  logic [31:0] col_inc;
  logic [31:0] rows_dec;
  logic        row_end;

  assign slot_free = !valid_r || out_pop;
  assign cmd_pop   = cmd_avail && slot_free;
  assign is_data   = cmd_pop && (cmd.kind == CMD_DATA) && active_r;
  assign emit_pix  = is_data && (col_r < 32'(w_r));
  assign emit      = emit_pix || (cmd_pop && cmd.kind == CMD_STATUS);
  assign col_inc   = col_r + 32'd1;
  assign row_end   = col_inc >= prl_r;
  assign rows_dec  = (rows_r != '0) ? rows_r - 32'd1 : rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
      col_r    <= '0;
      rows_r   <= '0;
    end else begin
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
      if (cmd_pop && cmd.kind == CMD_STATUS && cmd.status == ST_OK) begin
        active_r <= 1'b1;
        col_r    <= '0;
        rows_r   <= cmd.rows;
      end else if (is_data) begin
        if (row_end) begin
          col_r  <= '0;
          rows_r <= rows_dec;
          if (rows_dec == '0) begin
            active_r <= 1'b0;
          end
        end else begin
          col_r <= col_inc;
        end
      end
    end
  end

  // image geometry, only meaningful while active
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_STATUS) begin
      w_r   <= cmd.width;
      prl_r <= cmd.row_len;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (emit_pix) begin
        kind_r   <= KIND_PIXEL;
        status_r <= ST_OK;
        pixel_r  <= cmd.data;
        width_r  <= '0;
        height_r <= '0;
        offset_r <= '0;
        last_r   <= (rows_r == 32'd1) && (col_r == 32'(w_r) - 32'd1);
      end else begin
        kind_r   <= KIND_STATUS;
        status_r <= cmd.status;
        pixel_r  <= '0;
        width_r  <= cmd.width;
        height_r <= cmd.height;
        offset_r <= cmd.offset;
        last_r   <= 1'b0;
      end
    end
  end

  assign out_empty             = !valid_r;
  assign out_kind              = kind_r;
  assign out_status            = status_r;
  assign out_pixel             = pixel_r;
  assign out_image_width       = width_r;
  assign out_image_height      = height_r;
  assign out_pixel_data_offset = offset_r;
  assign out_last_pixel        = last_r;

endmodule
`default_nettype wire

/* hw/rtl/bmp8hc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmp8hc_checker
// Port-level checks of the bitmap parser, bound to the top level.
// ----------------------------------------------------------------------------
module bmp8hc_checker
  import bmp8hc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_pop,
  input wire logic        out_empty,
  input wire logic        out_kind,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_pixel,
  input wire logic [30:0] out_image_width,
  input wire logic [31:0] out_image_height,
  input wire logic [31:0] out_pixel_data_offset,
  input wire logic        out_last_pixel
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind)
      && $stable(out_status) && $stable(out_pixel) && $stable(out_last_pixel)))
    else $error("waiting result changed");

  a_pix_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_PIXEL) |-> (out_status == ST_OK
      && out_image_width == '0 && out_image_height == '0
      && out_pixel_data_offset == '0))
    else $error("pixel beat carries header fields");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_STATUS && out_status != ST_OK)
      |-> (out_image_width == '0 && out_image_height == '0
      && out_pixel_data_offset == '0 && out_pixel == '0 && !out_last_pixel))
    else $error("error status carries header fields");

endmodule

bind bmp8_header_check_and_row_unpad bmp8hc_checker u_checker (.*);
`default_nettype wire
